[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/ppt_pkg.sv]
`timescale 1ns / 1ps
package ppt_pkg;

	localparam int NumCoef = 8;
	localparam int CfgIdxW = 4;
	localparam int QuoBits = 33;

	localparam int H00 = 0;
	localparam int H01 = 1;
	localparam int H02 = 2;
	localparam int H10 = 3;
	localparam int H11 = 4;
	localparam int H12 = 5;
	localparam int H20 = 6;
	localparam int H21 = 7;

	localparam logic [31:0] CoefOne = 32'h0010_0000;

	typedef logic [NumCoef-1:0][31:0] ppt_coef_t;

	// Identity mapping, highest index first.
	localparam ppt_coef_t CoefReset = {
		32'h0, 32'h0, 32'h0, CoefOne, 32'h0, 32'h0, 32'h0, CoefOne
	};

	// One quotient lane of the divider.
	typedef struct packed {
		logic [63:0]        rem;
		logic [QuoBits-1:0] quo;
		logic [16:0]        nlow;
		logic               neg;
		logic               ovf;
	} ppt_lane_t;

	// Everything a point carries through the divider stages.
	typedef struct packed {
		logic        valid;
		logic        dz;
		logic [63:0] dmag;
		logic [31:0] inten;
		logic        isat;
		ppt_lane_t   row;
		ppt_lane_t   col;
	} ppt_div_t;

endpackage

[hdl/ppt_front.sv]
`timescale 1ns / 1ps
module ppt_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [31:0]     row,
	input  logic signed [31:0]     col,
	input  logic signed [31:0]     intensity,
	input  logic signed [31:0]     intensity_scale,
	input  ppt_pkg::ppt_coef_t     coef,
	output ppt_pkg::ppt_div_t      d_out
);

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [63:0] pd0_s1, pd1_s1, pa0_s1, pa1_s1, pb0_s1, pb1_s1, pi_s1;
	logic signed [31:0] offa_s1, offb_s1;

	logic signed [65:0] den_s2, na_s2, nb_s2;
	logic [63:0]        imag_s2;
	logic               ineg_s2;

	logic               dz_s3, dneg_s3, aneg_s3, bneg_s3, ineg_s3;
	logic [63:0]        dmag_s3, amag_s3, bmag_s3;
	logic [47:0]        irnd_s3;

	logic [31:0]        inten_c;
	logic               isat_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: all products.
	always_ff @(posedge clk) begin
		if (en) begin
			pd0_s1  <= $signed(coef[ppt_pkg::H20]) * row;
			pd1_s1  <= $signed(coef[ppt_pkg::H21]) * col;
			pa0_s1  <= $signed(coef[ppt_pkg::H00]) * row;
			pa1_s1  <= $signed(coef[ppt_pkg::H01]) * col;
			pb0_s1  <= $signed(coef[ppt_pkg::H10]) * row;
			pb1_s1  <= $signed(coef[ppt_pkg::H11]) * col;
			pi_s1   <= intensity * intensity_scale;
			offa_s1 <= $signed(coef[ppt_pkg::H02]);
			offb_s1 <= $signed(coef[ppt_pkg::H12]);
		end
	end

	// Stage 2: sums aligned to Q.36, intensity magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s2  <= 66'(pd0_s1) + 66'(pd1_s1) + (66'sd1 <<< 36);
			na_s2   <= 66'(pa0_s1) + 66'(pa1_s1) + (66'(offa_s1) <<< 16);
			nb_s2   <= 66'(pb0_s1) + 66'(pb1_s1) + (66'(offb_s1) <<< 16);
			ineg_s2 <= pi_s1[63];
			imag_s2 <= pi_s1[63] ? 64'(-pi_s1) : 64'(pi_s1);
		end
	end

	// Stage 3: sign and magnitude, intensity rounding.
	always_ff @(posedge clk) begin
		if (en) begin
			dz_s3   <= (den_s2 == '0);
			dneg_s3 <= den_s2[65];
			aneg_s3 <= na_s2[65];
			bneg_s3 <= nb_s2[65];
			dmag_s3 <= den_s2[65] ? 64'(-den_s2) : den_s2[63:0];
			amag_s3 <= na_s2[65] ? 64'(-na_s2) : na_s2[63:0];
			bmag_s3 <= nb_s2[65] ? 64'(-nb_s2) : nb_s2[63:0];
			ineg_s3 <= ineg_s2;
			irnd_s3 <= 48'((65'(imag_s2) + 65'h8000) >> 16);
		end
	end

	always_comb begin
		isat_c = 1'b0;
		if (ineg_s3) begin
			if (irnd_s3 > 48'h8000_0000) begin
				isat_c  = 1'b1;
				inten_c = 32'h8000_0000;
			end else begin
				inten_c = 32'(-irnd_s3);
			end
		end else if (irnd_s3 > 48'h7FFF_FFFF) begin
			isat_c  = 1'b1;
			inten_c = 32'h7FFF_FFFF;
		end else begin
			inten_c = irnd_s3[31:0];
		end
	end

	// Stage 4: overflow test and divider set-up. A quotient of 2^33 or more
	// clamps whatever its low bits are, so only 33 quotient bits are formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out.valid    <= valid_s3;
			d_out.dz       <= dz_s3;
			d_out.dmag     <= dmag_s3;
			d_out.inten    <= inten_c;
			d_out.isat     <= isat_c;
			d_out.row.rem  <= 64'(amag_s3 >> 17);
			d_out.row.quo  <= '0;
			d_out.row.nlow <= amag_s3[16:0];
			d_out.row.neg  <= aneg_s3 ^ dneg_s3;
			d_out.row.ovf  <= {17'b0, amag_s3} >= {dmag_s3, 17'b0};
			d_out.col.rem  <= 64'(bmag_s3 >> 17);
			d_out.col.quo  <= '0;
			d_out.col.nlow <= bmag_s3[16:0];
			d_out.col.neg  <= bneg_s3 ^ dneg_s3;
			d_out.col.ovf  <= {17'b0, bmag_s3} >= {dmag_s3, 17'b0};
		end
	end

endmodule

[hdl/ppt_div_step.sv]
`timescale 1ns / 1ps
module ppt_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ppt_pkg::ppt_div_t d_in,
	output ppt_pkg::ppt_div_t d_out
);

	ppt_pkg::ppt_lane_t row_c, col_c;

	function automatic ppt_pkg::ppt_lane_t lane_step(ppt_pkg::ppt_lane_t l,
		logic [63:0] d);
		ppt_pkg::ppt_lane_t r;
		logic [64:0]        t;
		r = l;
		t = {l.rem, l.nlow[16]};
		r.nlow = {l.nlow[15:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem = 64'(t - {1'b0, d});
			r.quo = {l.quo[ppt_pkg::QuoBits-2:0], 1'b1};
		end else begin
			r.rem = t[63:0];
			r.quo = {l.quo[ppt_pkg::QuoBits-2:0], 1'b0};
		end
		return r;
	endfunction

	assign row_c = lane_step(d_in.row, d_in.dmag);
	assign col_c = lane_step(d_in.col, d_in.dmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out.valid <= d_in.valid;
			d_out.dz    <= d_in.dz;
			d_out.dmag  <= d_in.dmag;
			d_out.inten <= d_in.inten;
			d_out.isat  <= d_in.isat;
			d_out.row   <= row_c;
			d_out.col   <= col_c;
		end
	end

endmodule

[hdl/ppt_back.sv]
`timescale 1ns / 1ps
module ppt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ppt_pkg::ppt_div_t d_in,
	output logic              out_valid,
	output logic [31:0]       new_row,
	output logic [31:0]       new_col,
	output logic [31:0]       new_intensity,
	output logic              denominator_zero,
	output logic              saturated
);

	logic [31:0] row_v, col_v;
	logic        row_sat, col_sat;

	function automatic logic [32:0] lane_final(ppt_pkg::ppt_lane_t l, logic [63:0] d);
		logic [33:0] q;
		logic        sat;
		logic [31:0] v;
		q = 34'(l.quo) + 34'({l.rem, 1'b0} >= {1'b0, d});
		sat = 1'b0;
		if (l.neg) begin
			if (l.ovf || q > 34'h8000_0000) begin
				sat = 1'b1;
				v   = 32'h8000_0000;
			end else begin
				v = 32'(-q);
			end
		end else if (l.ovf || q > 34'h7FFF_FFFF) begin
			sat = 1'b1;
			v   = 32'h7FFF_FFFF;
		end else begin
			v = q[31:0];
		end
		return {sat, v};
	endfunction

	assign {row_sat, row_v} = lane_final(d_in.row, d_in.dmag);
	assign {col_sat, col_v} = lane_final(d_in.col, d_in.dmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_row          <= d_in.dz ? '0 : row_v;
			new_col          <= d_in.dz ? '0 : col_v;
			new_intensity    <= d_in.inten;
			denominator_zero <= d_in.dz;
			saturated        <= d_in.isat | (!d_in.dz & (row_sat | col_sat));
		end
	end

endmodule

[hdl/projective_point_transform.sv]
`timescale 1ns / 1ps
// Projective point transform. Each input transaction carries one point in
// signed Q16.16 and an intensity scale; each output transaction carries the
// point mapped through the configured eight-coefficient homography (signed
// Q12.20, the bottom-right entry fixed at one), the scaled intensity, a flag
// for an exactly zero denominator and a flag for any clamped value. Quotients
// and the intensity product round to nearest with ties away from zero. The
// block takes one point in every cycle while the pipeline is not held. Each
// point passes through stages of multiply, sum, magnitude and range test, a
// restoring divider that forms one quotient bit per stage for the row and
// column at once, and a stage of rounding and clamping into the output
// register. When a valid output is stalled the whole pipeline holds, and
// in_stall follows out_valid and out_stall. The eight coefficients are
// written through the configuration port, which is always ready; indexes
// beyond the eighth are ignored. Configuration should be changed only while
// no point is in flight.
`include "assert_macros.svh"
module projective_point_transform (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ppt_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [31:0]           row,
	input  logic signed [31:0]           col,
	input  logic signed [31:0]           intensity,
	input  logic signed [31:0]           intensity_scale,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  new_row,
	output logic [31:0]                  new_col,
	output logic [31:0]                  new_intensity,
	output logic                         denominator_zero,
	output logic                         saturated
);

	ppt_pkg::ppt_coef_t coef_q;
	ppt_pkg::ppt_div_t  div_pipe [0:ppt_pkg::QuoBits];
	logic               en;

	// The pipeline moves whenever the output register is free or being read.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Coefficient registers, reset to the identity mapping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= ppt_pkg::CoefReset;
		end else if (cfg_valid && cfg_index < ppt_pkg::CfgIdxW'(ppt_pkg::NumCoef)) begin
			coef_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	ppt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (in_valid),
		.row             (row),
		.col             (col),
		.intensity       (intensity),
		.intensity_scale (intensity_scale),
		.coef            (coef_q),
		.d_out           (div_pipe[0])
	);

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < ppt_pkg::QuoBits; i++) begin : g_div
		ppt_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (div_pipe[i]),
			.d_out  (div_pipe[i+1])
		);
	end

	ppt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.d_in             (div_pipe[ppt_pkg::QuoBits]),
		.out_valid        (out_valid),
		.new_row          (new_row),
		.new_col          (new_col),
		.new_intensity    (new_intensity),
		.denominator_zero (denominator_zero),
		.saturated        (saturated)
	);

	// A zero denominator always yields the origin.
	`ASSERT_IMPL(a_dz_origin, clk, arst_n, out_valid && denominator_zero, new_row == 32'h0 && new_col == 32'h0)
	// With the output held, the divider entry stage must hold too.
	`ASSERT_NEXT(a_hold_pipe, clk, arst_n, out_valid && out_stall, $stable(div_pipe[0].valid))
	// With a zero denominator only a clamped intensity can raise the flag.
	`ASSERT_IMPL(a_dz_sat, clk, arst_n, out_valid && denominator_zero && new_intensity != 32'h7FFF_FFFF && new_intensity != 32'h8000_0000, !saturated)

endmodule
